### src/csa_pkg.sv
`default_nettype none

package csa_pkg;

  // Built slot table size
  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;

  // Fixed field widths
  localparam int ACT_W   = 2;
  localparam int LEN_W   = 16;
  localparam int SCNT_W  = 7;
  localparam int BYTES_W = 11;
  localparam int CFG_W   = 11;
  localparam int START_W = 6;
  localparam int RCNT_W  = 7;

  // Divider sizing: dividend is length + slot_bytes - 1
  localparam int DIVD_W = LEN_W + 1;
  localparam int REM_W  = BYTES_W + 1;
  localparam int STEP_W = $clog2(DIVD_W);

  // Free count sweep: GRP slots per cycle
  localparam int GRP       = 8;
  localparam int GRP_W     = $clog2(GRP);
  localparam int NGRP      = (MAX_SLOTS + GRP - 1) / GRP;
  localparam int GRP_IDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic [SCNT_W-1:0]  RESET_SLOT_COUNT = SCNT_W'(64);
  localparam logic [BYTES_W-1:0] RESET_SLOT_BYTES = BYTES_W'(16);

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT   = 2'd2;

  localparam logic CFG_SLOT_COUNT = 1'b0;
  localparam logic CFG_SLOT_BYTES = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [LEN_W-1:0]   value_length;
    logic [START_W-1:0] start_slot;
    logic [RCNT_W-1:0]  release_count;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [5:0]        run_start;
    logic [6:0]        slots_needed;
    logic [6:0]        free_slots;
  } result_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic mark;
    logic rel;
    logic cnt_step;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic alloc_skip;
    logic scan_hit;
    logic scan_last;
    logic cnt_last;
  } stat_t;

endpackage

`default_nettype wire

### src/csa_ctrl.sv
`default_nettype none

module csa_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [csa_pkg::ACT_W-1:0] action_i,
  input  wire csa_pkg::stat_t            stat_i,
  output csa_pkg::cmd_t                  cmd_o,
  output logic                           busy_o,
  output logic                           done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_REL,
    S_COUNT
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i == csa_pkg::ACT_ALLOC) begin
            state_d = S_DIV;
          end else if (action_i == csa_pkg::ACT_RELEASE) begin
            state_d = S_REL;
          end else begin
            state_d = S_COUNT;
          end
        end
      end
      S_DIV: begin
        if (stat_i.div_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = stat_i.alloc_skip ? S_COUNT : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          state_d = S_MARK;
        end else if (stat_i.scan_last) begin
          state_d = S_COUNT;
        end
      end
      S_MARK:  state_d = S_COUNT;
      S_REL:   state_d = S_COUNT;
      S_COUNT: begin
        if (stat_i.cnt_last) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.scan_step = (state_q == S_SCAN);
    cmd_o.mark      = (state_q == S_MARK);
    cmd_o.rel       = (state_q == S_REL);
    cmd_o.cnt_step  = (state_q == S_COUNT);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

### src/csa_dp.sv
`default_nettype none

module csa_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [csa_pkg::CFG_W-1:0] cfg_data_i,
  input  wire csa_pkg::item_t            item_i,
  input  wire csa_pkg::cmd_t             cmd_i,
  output csa_pkg::stat_t                 stat_o,
  output csa_pkg::result_t               result_o
);

  localparam int MS       = csa_pkg::MAX_SLOTS;
  localparam int SW       = csa_pkg::SLOT_W;
  localparam int CW       = csa_pkg::CNT_W;
  localparam int DW       = csa_pkg::DIVD_W;
  localparam int RW       = csa_pkg::REM_W;
  localparam int BW       = csa_pkg::BYTES_W;
  localparam int SCW      = csa_pkg::SCNT_W;
  localparam int GW       = csa_pkg::GRP_W;
  localparam int GIW      = csa_pkg::GRP_IDX_W;
  localparam int PAD_W    = csa_pkg::NGRP * csa_pkg::GRP;
  localparam int SIDX_W   = GIW + GW;
  localparam int STEP_W_L = csa_pkg::STEP_W - 1;

  // Configuration
  logic [SCW-1:0] slot_count_q;
  logic [BW-1:0]  slot_bytes_q;

  // Slot table
  logic [MS-1:0] busy_q, busy_d;

  // Latched request
  logic [csa_pkg::ACT_W-1:0]   act_q;
  logic [csa_pkg::START_W-1:0] start_q;
  logic [csa_pkg::RCNT_W-1:0]  rcount_q;

  // Divider
  logic [DW-1:0]     dq_q, dq_d;
  logic [RW-1:0]     rem_q, rem_d, rem_sh;
  logic [STEP_W_L:0] step_q;

  // Scan
  logic [CW-1:0] idx_q, run_q, run_inc;
  logic [SW-1:0] pos_q;
  logic          found_q;

  // Free count
  logic [GIW-1:0] grp_q;
  logic [CW-1:0]  cnt_q, grp_sum;

  logic [BW-1:0]  bytes_eff;
  logic [SCW-1:0] used_n;
  logic           over;
  logic [CW-1:0]  need;
  logic           ge;
  logic           slot_free;
  logic [CW:0]    mark_end, rel_end;
  logic [MS-1:0]  alloc_mask, rel_mask;
  logic [PAD_W-1:0] busy_pad;
  logic [csa_pkg::GRP-1:0] gbits;
  logic [SIDX_W-1:0] sidx;

  assign bytes_eff = (slot_bytes_q == '0) ? BW'(1) : slot_bytes_q;
  assign used_n    = (slot_count_q > SCW'(MS)) ? SCW'(MS) : slot_count_q;

  // Quotient after the last divide step
  assign over = (dq_q > DW'(MS));
  assign need = over ? CW'(MS) : dq_q[CW-1:0];

  // Restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[RW-2:0], dq_q[DW-1]};
    ge     = (rem_sh >= {1'b0, bytes_eff});
    rem_d  = ge ? (rem_sh - {1'b0, bytes_eff}) : rem_sh;
    dq_d   = {dq_q[DW-2:0], ge};
  end

  assign run_inc   = run_q + CW'(1);
  assign slot_free = !busy_q[idx_q[SW-1:0]];

  assign mark_end = {1'b0, CW'(pos_q)} + {1'b0, need};
  assign rel_end  = (CW+1)'(start_q) + (CW+1)'(rcount_q);

  always_comb begin
    for (int j = 0; j < MS; j++) begin
      alloc_mask[j] = ((CW+1)'(j) >= (CW+1)'(pos_q)) && ((CW+1)'(j) < mark_end);
      rel_mask[j]   = ((CW+1)'(j) >= (CW+1)'(start_q)) && ((CW+1)'(j) < rel_end)
                      && ((CW+1)'(j) < (CW+1)'(used_n));
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.mark) begin
      busy_d = busy_q | alloc_mask;
    end else if (cmd_i.rel) begin
      busy_d = busy_q & ~rel_mask;
    end
  end

  // Free slots in one group of the table
  always_comb begin
    busy_pad           = '1;
    busy_pad[MS-1:0]   = busy_q;
    gbits              = busy_pad[{grp_q, GW'(0)} +: csa_pkg::GRP];
    grp_sum            = '0;
    sidx               = '0;
    for (int k = 0; k < csa_pkg::GRP; k++) begin
      sidx = {grp_q, GW'(k)};
      if (!gbits[k] && ((SCW + SIDX_W)'(sidx) < (SCW + SIDX_W)'(used_n))) begin
        grp_sum = grp_sum + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= csa_pkg::RESET_SLOT_COUNT;
      slot_bytes_q <= csa_pkg::RESET_SLOT_BYTES;
      busy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          csa_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data_i[SCW-1:0];
          csa_pkg::CFG_SLOT_BYTES: slot_bytes_q <= cfg_data_i[BW-1:0];
          default: ;
        endcase
      end
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= item_i.action;
      start_q  <= item_i.start_slot;
      rcount_q <= item_i.release_count;
      dq_q     <= DW'(item_i.value_length) + DW'(bytes_eff) - DW'(1);
      rem_q    <= '0;
      step_q   <= '0;
      idx_q    <= '0;
      run_q    <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
      grp_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.div_step) begin
        dq_q   <= dq_d;
        rem_q  <= rem_d;
        step_q <= step_q + (STEP_W_L + 1)'(1);
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + CW'(1);
        run_q <= slot_free ? run_inc : '0;
        if (stat_o.scan_hit) begin
          pos_q <= SW'(idx_q + CW'(1) - need);
        end
      end
      if (cmd_i.mark) begin
        found_q <= 1'b1;
      end
      if (cmd_i.cnt_step) begin
        grp_q <= grp_q + GIW'(1);
        cnt_q <= cnt_q + grp_sum;
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.div_last   = (step_q == (STEP_W_L + 1)'(DW - 1));
    stat_o.alloc_skip = (dq_q == '0) || over || (need > CW'(used_n));
    stat_o.scan_hit   = slot_free && (run_inc == need);
    stat_o.scan_last  = ((idx_q + CW'(1)) == CW'(used_n));
    stat_o.cnt_last   = (grp_q == GIW'(csa_pkg::NGRP - 1));
  end

  always_comb begin
    result_o              = '0;
    result_o.found        = found_q;
    result_o.run_start    = found_q ? 6'(pos_q) : 6'd0;
    result_o.slots_needed = (act_q == csa_pkg::ACT_ALLOC) ? 7'(need) : 7'd0;
    result_o.free_slots   = 7'(cnt_q);
  end

endmodule

`default_nettype wire

### src/contiguous_slot_allocator.sv
// Allocate divides, checks, scans up to 64 slots and marks a found run; release
//   clears its run; every item, a free count report too, ends with the count sweep.
// One item at a time; the 17-step divider and the one-slot-per-cycle scan
//   set the allocate time, the free count sweep takes 8 slots a cycle.
// done_o is high for one cycle with result_o; the receiver cannot stall.
// Reset frees all slots and loads slot_count 64 and slot_bytes 16.
`default_nettype none

module contiguous_slot_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire csa_pkg::item_t            item_i,
  output logic                           done_o,
  output csa_pkg::result_t               result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [csa_pkg::CFG_W-1:0] cfg_data_i
);

  csa_pkg::cmd_t  cmd;
  csa_pkg::stat_t stat;

  csa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (item_i.action),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  csa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o)
  );

  // An accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while still working");

  a_found_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |->
      (result_o.slots_needed != 7'd0) &&
      ((8'(result_o.run_start) + 8'(result_o.slots_needed)) <= 8'(csa_pkg::MAX_SLOTS)))
    else $error("allocated run does not fit the table");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.free_slots <= 7'(csa_pkg::MAX_SLOTS)))
    else $error("free count beyond table size");

endmodule

`default_nettype wire

### bench/csa_checker.sv
module csa_checker
  import csa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  item_t            item_i,
  input  logic             done_i,
  input  result_t          result_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               err_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MAX_SLOTS-1:0] slot_map;
  logic [SCNT_W-1:0]    live_count;
  logic [BYTES_W-1:0]   live_bytes;
  result_t              due_replies[$];
  result_t              want;

  // Apply one request to the local slot map and return the reply it earns.
  function automatic result_t serve_request(item_t rq);
    result_t r;
    int lim, unit, need, run, pos, stop, free_cnt;
    r = '0;
    lim = (live_count > MAX_SLOTS) ? MAX_SLOTS : int'(live_count);
    if (rq.action == ACT_ALLOC) begin
      unit = (live_bytes == 0) ? 1 : int'(live_bytes);
      need = (int'(rq.value_length) + unit - 1) / unit;
      pos = -1;
      if (need > 0 && need <= lim) begin
        run = 0;
        for (int i = 0; i < lim; i++) begin
          if (slot_map[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == need && pos < 0) pos = i + 1 - need;
          end
        end
      end
      if (pos >= 0) begin
        for (int i = pos; i < pos + need; i++) slot_map[i] = 1'b1;
        r.found = 1'b1;
        r.run_start = 6'(pos);
      end
      r.slots_needed = (need > 64) ? 7'd64 : 7'(need);
    end else if (rq.action == ACT_RELEASE) begin
      stop = int'(rq.start_slot) + int'(rq.release_count);
      if (stop > lim) stop = lim;
      for (int i = int'(rq.start_slot); i < stop; i++) slot_map[i] = 1'b0;
    end
    free_cnt = 0;
    for (int i = 0; i < lim; i++) if (!slot_map[i]) free_cnt++;
    r.free_slots = 7'(free_cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_map    = '0;
      live_count  = RESET_SLOT_COUNT;
      live_bytes  = RESET_SLOT_BYTES;
      due_replies.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // compare before queuing, a new item can never be answered at its own edge
      if (done_i) begin
        if (due_replies.size() == 0) begin
          $error("result with no item outstanding: %p", result_i);
          err_count_o++;
        end else begin
          want = due_replies.pop_front();
          if (result_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, result_i.found);
            err_count_o++;
          end
          if (result_i.run_start !== want.run_start) begin
            $error("run_start: expected %0d, actual %0d", want.run_start,
                   result_i.run_start);
            err_count_o++;
          end
          if (result_i.slots_needed !== want.slots_needed) begin
            $error("slots_needed: expected %0d, actual %0d", want.slots_needed,
                   result_i.slots_needed);
            err_count_o++;
          end
          if (result_i.free_slots !== want.free_slots) begin
            $error("free_slots: expected %0d, actual %0d", want.free_slots,
                   result_i.free_slots);
            err_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SLOT_COUNT) live_count = cfg_data_i[SCNT_W-1:0];
        else live_bytes = cfg_data_i[BYTES_W-1:0];
      end
      if (start_i && !busy_i) due_replies.push_back(serve_request(item_i));
      pending_o = due_replies.size();
    end
  end

endmodule

### bench/contiguous_slot_allocator_tb.sv
module contiguous_slot_allocator_tb;
  import csa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS  = 800;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          SETTLE_CYCLES = 100;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             req_start = 1'b0;
  item_t            req_item = '0;
  logic             busy;
  logic             done;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = CFG_SLOT_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  int               err_count;
  int               pending;
  int               idle_pct = 0;
  int               shape_slots = 64;
  int               shape_bytes = 16;
  int               quiet = 0;

  contiguous_slot_allocator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (req_start),
    .busy       (busy),
    .item_i     (req_item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  csa_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (req_start),
    .busy_i      (busy),
    .item_i      (req_item),
    .done_i      (done),
    .result_i    (result),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles with no item taken and no result given.
  always @(posedge clk) begin
    if (!rst_n || (req_start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("contiguous_slot_allocator test failed");
        $finish;
      end
    end
  end

  function automatic item_t request(logic [ACT_W-1:0] act, int len, int first, int cnt);
    item_t it;
    it.action        = act;
    it.value_length  = LEN_W'(len);
    it.start_slot    = START_W'(first);
    it.release_count = RCNT_W'(cnt);
    return it;
  endfunction

  // Mostly runs that fit the current table, some raw noise in every field.
  function automatic item_t random_request();
    item_t it;
    int roll, span, unit;
    it.action        = ACT_W'($urandom);
    it.value_length  = LEN_W'($urandom);
    it.start_slot    = START_W'($urandom);
    it.release_count = RCNT_W'($urandom);
    span = (shape_slots > 64) ? 64 : (shape_slots < 1) ? 1 : shape_slots;
    unit = (shape_bytes == 0) ? 1 : shape_bytes;
    roll = $urandom_range(99);
    if (roll < 45) begin
      it.action = ACT_ALLOC;
      roll = $urandom_range(19);
      if (roll == 1) it.value_length = '0;
      else if (roll != 0)
        it.value_length = LEN_W'($urandom_range(1, unit * $urandom_range(1, 6)));
    end else if (roll < 80) begin
      it.action = ACT_RELEASE;
      if ($urandom_range(6) != 0) begin
        it.start_slot    = START_W'($urandom_range(0, span - 1));
        it.release_count = RCNT_W'($urandom_range(1, 8));
      end
    end else if (roll < 95) begin
      it.action = ACT_COUNT;
    end else begin
      it.action = ACT_SPARE;
    end
    return it;
  endfunction

  // Present one item, idling first as the current phase asks.
  task automatic issue(item_t it);
    if (idle_pct != 0 && $urandom_range(9) == 0) begin
      req_start = 1'b0;
      repeat ($urandom_range(1, 100)) @(negedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      req_start = 1'b0;
      @(negedge clk);
    end
    req_start = 1'b1;
    req_item  = it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold the sender until every reply is in and the block is idle.
  task automatic drain();
    req_start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    drain();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_W'(val);
    if (idx == CFG_SLOT_COUNT) shape_slots = val & 'h7f;
    else shape_bytes = val & 'h7ff;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_config();
    int cnt, unit;
    case ($urandom_range(19))
      0:       cnt = 0;
      1:       cnt = 1;
      2, 3:    cnt = 64;
      4:       cnt = 127;
      default: cnt = $urandom_range(2, 63);
    endcase
    case ($urandom_range(9))
      0:       unit = 0;
      1:       unit = 1;
      2:       unit = 2047;
      3:       unit = 1024;
      default: unit = $urandom_range(2, 64);
    endcase
    write_reg(CFG_SLOT_COUNT, cnt);
    write_reg(CFG_SLOT_BYTES, unit);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_SLOT_COUNT, 64);
    write_reg(CFG_SLOT_BYTES, 16);
    issue(request(ACT_COUNT, 0, 0, 0));
    issue(request(ACT_ALLOC, 0, 0, 0));
    issue(request(ACT_ALLOC, 1, 0, 0));
    issue(request(ACT_ALLOC, 16, 0, 0));
    issue(request(ACT_ALLOC, 17, 0, 0));
    issue(request(ACT_ALLOC, 65535, 63, 127));
    issue(request(ACT_ALLOC, 1024, 0, 0));
    issue(request(ACT_RELEASE, 0, 1, 1));
    issue(request(ACT_ALLOC, 16, 0, 0));
    issue(request(ACT_RELEASE, 0, 63, 127));
    issue(request(ACT_RELEASE, 0, 0, 0));
    issue(request(ACT_SPARE, 0, 0, 0));
    issue(request(ACT_RELEASE, 0, 0, 64));
    issue(request(ACT_ALLOC, 1024, 0, 0));
    issue(request(ACT_ALLOC, 1, 0, 0));
    // shrink the table: marks above it stay put and come back later
    write_reg(CFG_SLOT_COUNT, 8);
    issue(request(ACT_RELEASE, 0, 0, 4));
    issue(request(ACT_COUNT, 0, 0, 0));
    write_reg(CFG_SLOT_COUNT, 0);
    issue(request(ACT_ALLOC, 5, 0, 0));
    issue(request(ACT_COUNT, 0, 0, 0));
    write_reg(CFG_SLOT_COUNT, 127);
    issue(request(ACT_COUNT, 0, 0, 0));
    issue(request(ACT_RELEASE, 0, 0, 127));
    write_reg(CFG_SLOT_BYTES, 0);
    issue(request(ACT_ALLOC, 3, 0, 0));
    write_reg(CFG_SLOT_BYTES, 2047);
    issue(request(ACT_ALLOC, 65535, 0, 0));
    issue(request(ACT_ALLOC, 2048, 0, 0));
    issue(request(ACT_RELEASE, 65535, 63, 1));

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 80 : 0;
      for (int k = 0; k < (RANDOM_ITEMS + 2) / 3; k++) begin
        if (k % 90 == 0) pick_config();
        else if ($urandom_range(99) == 0) drain();
        issue(random_request());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("contiguous_slot_allocator test passed");
    end else begin
      $display("contiguous_slot_allocator test failed");
    end
    $finish;
  end

endmodule
